[src/irns_pkg.sv]
// Shared types and constants for the rotating nearest-neighbour sampler.
// Depends on nothing; every other file in src imports it.
package irns_pkg;

  localparam int POS_W     = 10;  // input column and row
  localparam int PIX_W     = 8;   // grey value
  localparam int COEF_W    = 16;  // Q2.14 coefficients
  localparam int OFS_W     = 11;  // signed offsets
  localparam int DIM_W     = 9;   // frame size registers
  localparam int FRAC_BITS = 14;
  localparam int DELTA_W   = 12;  // col - offset_x, row - offset_y
  localparam int PROD_W    = COEF_W + DELTA_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int MAG_W     = SUM_W - FRAC_BITS;
  localparam int LIM_W     = 11;  // holds frame limits up to 1024
  localparam int REG_IDX_W = 3;
  localparam int REG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 8;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int STAGES      = 4;  // registered stages in the front part
  localparam int FLIGHT_W    = $clog2(STAGES + 1);

  localparam logic [REG_IDX_W-1:0] REG_COS_COEF   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIN_COEF   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd5;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  // One classified job leaving the front part.
  typedef struct packed {
    logic               push;
    kind_t              kind;
    logic               outside;
    logic [PIX_W-1:0]   pixel;
  } job_t;

endpackage

[src/irns_front.sv]
// Front part: takes items, maps sample positions back into the source frame
// and classifies each as a store write, an inside read or an outside result.
// Depends on irns_pkg.
module irns_front import irns_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ADDR_W     = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      mode,
  input  logic [POS_W-1:0]          col,
  input  logic [POS_W-1:0]          row,
  input  logic [PIX_W-1:0]          pixel_in,
  input  logic signed [COEF_W-1:0]  cos_coef,
  input  logic signed [COEF_W-1:0]  sin_coef,
  input  logic signed [OFS_W-1:0]   offset_x,
  input  logic signed [OFS_W-1:0]   offset_y,
  input  logic [DIM_W-1:0]          src_width,
  input  logic [DIM_W-1:0]          src_height,
  output job_t                      job,
  output logic [ADDR_W-1:0]         job_addr,
  output logic [FLIGHT_W-1:0]       in_flight
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } rnd_t;

  // Round half away from zero; neg is set only for a non-zero negative result.
  function automatic rnd_t round_q14(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] biased;
    rnd_t             r;
    mag    = v[SUM_W-1] ? (~v + 1'b1) : v;
    biased = mag + SUM_W'(1 << (FRAC_BITS - 1));
    r.mag  = biased[SUM_W-1:FRAC_BITS];
    r.neg  = v[SUM_W-1] && (r.mag != '0);
    return r;
  endfunction

  // stage A: offsets removed, load address formed
  logic                      a_valid, a_keep;
  kind_t                     a_kind;
  logic [PIX_W-1:0]          a_pix;
  logic [ADDR_W-1:0]         a_addr;
  logic signed [DELTA_W-1:0] a_dx, a_dy;
  // stage B: four products
  logic                      b_valid, b_keep;
  kind_t                     b_kind;
  logic [PIX_W-1:0]          b_pix;
  logic [ADDR_W-1:0]         b_addr;
  logic signed [PROD_W-1:0]  b_cdx, b_sdy, b_sdx, b_cdy;
  // stage C: exact sums
  logic                      c_valid, c_keep;
  kind_t                     c_kind;
  logic [PIX_W-1:0]          c_pix;
  logic [ADDR_W-1:0]         c_addr;
  logic signed [SUM_W-1:0]   c_u, c_v;
  // stage D: rounded source position
  logic                      d_valid, d_keep;
  kind_t                     d_kind;
  logic [PIX_W-1:0]          d_pix;
  logic [ADDR_W-1:0]         d_addr;
  rnd_t                      d_x, d_y;

  logic                      col_ok, row_ok;
  logic [ADDR_W-1:0]         load_addr;
  logic [LIM_W-1:0]          lim_w, lim_h;
  logic                      in_frame;
  logic [ADDR_W-1:0]         smp_addr;

  assign col_ok    = {1'b0, col} < LIM_W'(MAX_WIDTH);
  assign row_ok    = {1'b0, row} < LIM_W'(MAX_HEIGHT);
  assign load_addr = ADDR_W'(row[ROW_W-1:0] * MAX_WIDTH) + ADDR_W'(col[COL_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_kind <= kind_t'(mode);
    a_keep <= mode || (col_ok && row_ok);
    a_pix  <= pixel_in;
    a_addr <= load_addr;
    a_dx   <= $signed({2'b00, col}) - $signed({offset_x[OFS_W-1], offset_x});
    a_dy   <= $signed({2'b00, row}) - $signed({offset_y[OFS_W-1], offset_y});

    b_kind <= a_kind;
    b_keep <= a_keep;
    b_pix  <= a_pix;
    b_addr <= a_addr;
    b_cdx  <= cos_coef * a_dx;
    b_sdy  <= sin_coef * a_dy;
    b_sdx  <= sin_coef * a_dx;
    b_cdy  <= cos_coef * a_dy;

    c_kind <= b_kind;
    c_keep <= b_keep;
    c_pix  <= b_pix;
    c_addr <= b_addr;
    c_u    <= $signed({b_cdx[PROD_W-1], b_cdx}) - $signed({b_sdy[PROD_W-1], b_sdy});
    c_v    <= $signed({b_sdx[PROD_W-1], b_sdx}) + $signed({b_cdy[PROD_W-1], b_cdy});

    d_kind <= c_kind;
    d_keep <= c_keep;
    d_pix  <= c_pix;
    d_addr <= c_addr;
    d_x    <= round_q14(c_u);
    d_y    <= round_q14(c_v);
  end

  // frame in use, clipped to the store
  assign lim_w = (LIM_W'(src_width) > LIM_W'(MAX_WIDTH))  ? LIM_W'(MAX_WIDTH)  : LIM_W'(src_width);
  assign lim_h = (LIM_W'(src_height) > LIM_W'(MAX_HEIGHT)) ? LIM_W'(MAX_HEIGHT)
                                                          : LIM_W'(src_height);

  assign in_frame = !d_x.neg && (d_x.mag < MAG_W'(lim_w)) &&
                    !d_y.neg && (d_y.mag < MAG_W'(lim_h));
  assign smp_addr = ADDR_W'(d_y.mag[ROW_W-1:0] * MAX_WIDTH) + ADDR_W'(d_x.mag[COL_W-1:0]);

  always_comb begin
    job.push    = d_valid && d_keep;
    job.kind    = d_kind;
    job.outside = (d_kind == KIND_SAMPLE) && !in_frame;
    job.pixel   = d_pix;
    job_addr    = (d_kind == KIND_SAMPLE) ? smp_addr : d_addr;
  end

  assign in_flight = FLIGHT_W'($countones({a_valid, b_valid, c_valid, d_valid}));

endmodule

[src/irns_queue.sv]
// Short FIFO between the front and back parts.
// Depends on irns_pkg for its depth and count width.
module irns_queue import irns_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head,
  output logic              not_empty,
  output logic [QCNT_W-1:0] count
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [DATA_W-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic              full;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");
`endif

endmodule

[src/irns_back.sv]
// Back part: holds the source frame, performs store writes and reads,
// and drives the result strobe. Depends on irns_pkg.
module irns_back import irns_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ADDR_W     = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_ready,
  input  kind_t             job_kind,
  input  logic              job_outside,
  input  logic [PIX_W-1:0]  job_pixel,
  input  logic [ADDR_W-1:0] job_addr,
  output logic              pop,
  output logic              done,
  output logic [PIX_W-1:0]  pixel_out,
  output logic              outside
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [PIX_W-1:0] frame_mem [DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic             res_valid, res_outside;

  // never stalls: take the head job whenever there is one
  assign pop = job_ready;

  always_ff @(posedge clk) begin
    if (pop && (job_kind == KIND_LOAD)) begin
      frame_mem[job_addr] <= job_pixel;
    end
    rd_data <= frame_mem[job_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      res_outside <= 1'b0;
    end else begin
      res_valid   <= pop && (job_kind == KIND_SAMPLE);
      res_outside <= job_outside;
    end
  end

  assign done      = res_valid;
  assign outside   = res_outside;
  assign pixel_out = res_outside ? '0 : rd_data;

`ifndef SYNTHESIS
  a_done_from_sample: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pop && (job_kind == KIND_SAMPLE)))
    else $error("result without a sample job");
`endif

endmodule

[src/image_rotate_nearest_sampler_unit.sv]
// Top level of the rotating nearest-neighbour sampler: configuration
// registers, front mapping pipeline, job queue and frame store back end.
// Depends on irns_pkg, irns_front, irns_queue and irns_back.
//
// Usage:
//   Items enter on start while busy is low; mode 0 writes pixel_in into the
//   source frame at (row, col), mode 1 asks for output pixel (row, col).
//   Loads beyond the frame store are dropped and give no result.
//   Each sample gives one result: pixel_out and outside, shown for exactly
//   one cycle with done high. The receiver cannot hold results off.
//   Path: a sample passes four mapping stages, one queue hop and one
//   registered memory read on its way to done.
//   Throughput: one item per clock while busy is low, set by the single
//   frame store port, which takes one write or one read each cycle.
//   busy rises only if the job queue could overflow; the back end drains a
//   job every cycle, so in practice it stays low.
//   Configuration: wr_en, wr_addr, wr_data write a register at once; write
//   only while no item is in flight. Unknown indexes are ignored.
//   Reset: synchronous on rst; registers return to identity rotation and a
//   full 256 by 256 frame. The frame store is not cleared.
module image_rotate_nearest_sampler_unit import irns_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  // item channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode,
  input  logic [POS_W-1:0]      col,
  input  logic [POS_W-1:0]      row,
  input  logic [PIX_W-1:0]      pixel_in,
  // result channel
  output logic                  done,
  output logic [PIX_W-1:0]      pixel_out,
  output logic                  outside,
  // configuration write port
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_addr,
  input  logic [REG_DATA_W-1:0] wr_data
);

  localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int ENTRY_W = 1 + 1 + PIX_W + ADDR_W;

  // configuration registers
  logic signed [COEF_W-1:0] cos_coef, sin_coef;
  logic signed [OFS_W-1:0]  offset_x, offset_y;
  logic [DIM_W-1:0]         src_width, src_height;

  logic                  accept;
  job_t                  job;
  logic [ADDR_W-1:0]     job_addr;
  logic [FLIGHT_W-1:0]   in_flight;
  logic [ENTRY_W-1:0]    q_in, q_head;
  logic                  q_not_empty, q_pop;
  logic [QCNT_W-1:0]     q_count;
  logic [QCNT_W:0]       committed;

  // Hold configuration until written; reset to identity and full frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_coef   <= COEF_W'(1 << FRAC_BITS);
      sin_coef   <= '0;
      offset_x   <= '0;
      offset_y   <= '0;
      src_width  <= DIM_W'(256);
      src_height <= DIM_W'(256);
    end else if (wr_en) begin
      unique case (wr_addr)
        REG_COS_COEF:   cos_coef   <= wr_data[COEF_W-1:0];
        REG_SIN_COEF:   sin_coef   <= wr_data[COEF_W-1:0];
        REG_OFFSET_X:   offset_x   <= wr_data[OFS_W-1:0];
        REG_OFFSET_Y:   offset_y   <= wr_data[OFS_W-1:0];
        REG_SRC_WIDTH:  src_width  <= wr_data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height <= wr_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Count every job already committed to a queue slot: those queued plus
  // those still in the mapping stages. Stall new transactions once that
  // total would exceed the queue depth.
  assign committed = {1'b0, q_count} + (QCNT_W + 1)'(in_flight);
  assign busy      = committed >= (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept    = start && !busy;

  irns_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (mode),
    .col        (col),
    .row        (row),
    .pixel_in   (pixel_in),
    .cos_coef   (cos_coef),
    .sin_coef   (sin_coef),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .src_width  (src_width),
    .src_height (src_height),
    .job        (job),
    .job_addr   (job_addr),
    .in_flight  (in_flight)
  );

  // Pack a queue entry: kind, outside flag, pixel, frame address.
  assign q_in = {job.kind, job.outside, job.pixel, job_addr};

  irns_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job.push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  irns_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (ADDR_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_ready   (q_not_empty),
    .job_kind    (kind_t'(q_head[ENTRY_W-1])),
    .job_outside (q_head[ENTRY_W-2]),
    .job_pixel   (q_head[ADDR_W +: PIX_W]),
    .job_addr    (q_head[ADDR_W-1:0]),
    .pop         (q_pop),
    .done        (done),
    .pixel_out   (pixel_out),
    .outside     (outside)
  );

endmodule
